>>> rtl/core/quadratic_root_solver_core_defines.svh
// Assertion macros shared by the quadratic root solver RTL.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QRS_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("quadratic root solver check failed");
`define QRS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("quadratic root solver check failed");
`else
`define QRS_ASSERT_IMPL(lbl, pre, post)
`define QRS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/core/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
// No dependencies.
package qrs_pkg;

    localparam int VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_REPEATED = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } kind_t;

endpackage

>>> rtl/core/quadratic_root_solver_core.sv
// Pipeline: four discriminant stages, COEF_WIDTH + 1 square-root stages, one numerator stage
// and 34 divider stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// Uses qrs_pkg, qrs_disc, qrs_sqrt, qrs_div and the shared assertion macros.
`include "quadratic_root_solver_core_defines.svh"
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coef_a, coef_b, coef_c
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // first_value, second_value
    output logic [2:0]  m_axis_tuser    // root_kind, saturated
);

    localparam int CW  = COEF_WIDTH;
    localparam int SW  = CW + 1;
    localparam int NSW = CW + 3;
    localparam int NW  = CW + 2;
    localparam int TW  = 4 + CW + CW + 1;

    logic en;

    logic               d_vld, d_dneg, d_azero, d_aneg;
    logic [2*CW+1:0]    d_dmag;
    logic [CW-1:0]      d_aabs;
    logic signed [CW:0] d_nb;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    qrs_disc #(.CW(CW)) u_disc (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_axis_tvalid),
        .coef_a  (s_axis_tdata[31:0]),
        .coef_b  (s_axis_tdata[63:32]),
        .coef_c  (s_axis_tdata[95:64]),
        .out_vld (d_vld),
        .dmag    (d_dmag),
        .dneg    (d_dneg),
        .azero   (d_azero),
        .aneg    (d_aneg),
        .aabs    (d_aabs),
        .nb      (d_nb)
    );

    logic [TW-1:0] sq_tag_in, sq_tag_out;
    logic          sq_vld;
    logic [SW-1:0] sq_root;

    assign sq_tag_in = {d_dneg, (d_dmag == '0), d_azero, d_aneg, d_aabs, d_nb};

    qrs_sqrt #(.SW(SW), .TW(TW)) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (d_vld),
        .rad     (d_dmag),
        .in_tag  (sq_tag_in),
        .out_vld (sq_vld),
        .root    (sq_root),
        .out_tag (sq_tag_out)
    );

    logic               p_dneg, p_dzero, p_azero, p_aneg;
    logic [CW-1:0]      p_aabs;
    logic signed [CW:0] p_nb;
    logic signed [NSW-1:0] nbx, sx, n1, n2;
    logic [NW-1:0]      nb_mag, n1_mag, n2_mag;

    assign {p_dneg, p_dzero, p_azero, p_aneg, p_aabs, p_nb} = sq_tag_out;
    assign nbx = {{2{p_nb[CW]}}, p_nb};
    assign sx  = signed'({2'b00, sq_root});
    assign n1  = nbx + sx;
    assign n2  = nbx - sx;
    assign nb_mag = nbx[NSW-1] ? NW'(-nbx) : NW'(nbx);
    assign n1_mag = n1[NSW-1] ? NW'(-n1) : NW'(n1);
    assign n2_mag = n2[NSW-1] ? NW'(-n2) : NW'(n2);

    qrs_pkg::kind_t kind_next;
    logic [NW-1:0]  num0_next, num1_next;
    logic           sgn0_next, sgn1_next, zero0_next, zero1_next;

    always_comb
    begin
        kind_next  = qrs_pkg::KIND_TWO_REAL;
        num0_next  = n1_mag;
        num1_next  = n2_mag;
        sgn0_next  = n1[NSW-1] != p_aneg;
        sgn1_next  = n2[NSW-1] != p_aneg;
        zero0_next = 1'b0;
        zero1_next = 1'b0;
        priority if (p_azero)
        begin
            kind_next  = qrs_pkg::KIND_A_ZERO;
            zero0_next = 1'b1;
            zero1_next = 1'b1;
        end
        else if (p_dzero)
        begin
            kind_next  = qrs_pkg::KIND_REPEATED;
            num0_next  = nb_mag;
            sgn0_next  = p_nb[CW] != p_aneg;
            zero1_next = 1'b1;
        end
        else if (p_dneg)
        begin
            kind_next  = qrs_pkg::KIND_COMPLEX;
            num0_next  = nb_mag;
            sgn0_next  = p_nb[CW] != p_aneg;
            num1_next  = NW'(sq_root);
            sgn1_next  = 1'b0;
        end
        else
        begin
            kind_next  = qrs_pkg::KIND_TWO_REAL;
        end
    end

    logic           prep_vld_reg;
    qrs_pkg::kind_t kind_reg;
    logic [NW-1:0]  num0_reg, num1_reg;
    logic           neg0_reg, neg1_reg, zero0_reg, zero1_reg;
    logic [CW:0]    den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg  <= kind_next;
            num0_reg  <= num0_next;
            num1_reg  <= num1_next;
            neg0_reg  <= sgn0_next && (num0_next != '0);
            neg1_reg  <= sgn1_next && (num1_next != '0);
            zero0_reg <= zero0_next;
            zero1_reg <= zero1_next;
            den_reg   <= {p_aabs, 1'b0};
        end
    end

    logic                                v0_vld, v1_vld, sat0, sat1, kind_lo, kind_hi;
    logic [qrs_pkg::VALUE_WIDTH-1:0]     res0, res1;

    qrs_div #(.NW(NW), .DENW(CW + 1), .F(FRAC_BITS), .TW(1)) u_div_first (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (prep_vld_reg),
        .nmag    (num0_reg),
        .den     (den_reg),
        .neg     (neg0_reg),
        .zero    (zero0_reg),
        .in_tag  (kind_reg[0]),
        .out_vld (v0_vld),
        .result  (res0),
        .sat     (sat0),
        .out_tag (kind_lo)
    );

    qrs_div #(.NW(NW), .DENW(CW + 1), .F(FRAC_BITS), .TW(1)) u_div_second (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (prep_vld_reg),
        .nmag    (num1_reg),
        .den     (den_reg),
        .neg     (neg1_reg),
        .zero    (zero1_reg),
        .in_tag  (kind_reg[1]),
        .out_vld (v1_vld),
        .result  (res1),
        .sat     (sat1),
        .out_tag (kind_hi)
    );

    assign m_axis_tvalid = v0_vld;
    assign m_axis_tdata  = {res1, res0};
    assign m_axis_tuser  = {sat0 | sat1, kind_hi, kind_lo};

    `QRS_ASSERT_IMPL(a_lanes_agree, 1'b1, v0_vld == v1_vld)
    `QRS_ASSERT_IMPL(a_azero_clean, m_axis_tvalid && (m_axis_tuser[1:0] == qrs_pkg::KIND_A_ZERO), (m_axis_tdata == '0) && !m_axis_tuser[2])
    `QRS_ASSERT_IMPL(a_repeated_second_zero, m_axis_tvalid && (m_axis_tuser[1:0] == qrs_pkg::KIND_REPEATED), m_axis_tdata[63:32] == '0)
    `QRS_ASSERT_IMPL(a_imag_nonneg, m_axis_tvalid && (m_axis_tuser[1:0] == qrs_pkg::KIND_COMPLEX), !m_axis_tdata[63])
    `QRS_ASSERT_NEXT(a_stall_holds_prep, !s_axis_tready, $stable(prep_vld_reg))

endmodule

>>> rtl/core/qrs_disc.sv
// Discriminant front end: magnitudes, split partial products and b*b-4*a*c.
// Four register stages; no package dependencies.
module qrs_disc #(
    parameter int CW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [31:0]          coef_a,
    input  logic [31:0]          coef_b,
    input  logic [31:0]          coef_c,
    output logic                 out_vld,
    output logic [2*CW+1:0]      dmag,
    output logic                 dneg,
    output logic                 azero,
    output logic                 aneg,
    output logic [CW-1:0]        aabs,
    output logic signed [CW:0]   nb
);

    localparam int MW = (CW > 32) ? CW : 32;
    localparam int H  = (CW + 1) / 2;
    localparam int HW = CW - H;
    localparam int DW = 2 * CW + 2;

    logic [MW-1:0] wa, wb, wc;
    logic signed [CW-1:0] sa, sb, sc;
    logic [CW-1:0] aabs_next, babs_next, cabs_next;

    assign wa = MW'(coef_a);
    assign wb = MW'(coef_b);
    assign wc = MW'(coef_c);
    assign sa = signed'(wa[CW-1:0]);
    assign sb = signed'(wb[CW-1:0]);
    assign sc = signed'(wc[CW-1:0]);
    assign aabs_next = sa[CW-1] ? (~wa[CW-1:0] + 1'b1) : wa[CW-1:0];
    assign babs_next = sb[CW-1] ? (~wb[CW-1:0] + 1'b1) : wb[CW-1:0];
    assign cabs_next = sc[CW-1] ? (~wc[CW-1:0] + 1'b1) : wc[CW-1:0];

    // Stage 1
    logic v1_reg, aneg1_reg, cneg1_reg, czero1_reg, azero1_reg;
    logic [CW-1:0] aabs1_reg, babs1_reg, cabs1_reg;
    logic signed [CW:0] nb1_reg;

    // Stage 2
    logic v2_reg, aneg2_reg, cneg2_reg, czero2_reg, azero2_reg;
    logic [CW-1:0] aabs2_reg;
    logic signed [CW:0] nb2_reg;
    logic [2*H-1:0] pbl_reg, pal_reg;
    logic [CW-1:0] pbm_reg, pam1_reg, pam2_reg;
    logic [2*HW-1:0] pbh_reg, pah_reg;

    // Stage 3
    logic v3_reg, aneg3_reg, cneg3_reg, czero3_reg, azero3_reg;
    logic [CW-1:0] aabs3_reg;
    logic signed [CW:0] nb3_reg;
    logic [DW-1:0] b2_reg, ac4_reg;
    logic [DW-1:0] b2_next, ac_next;

    // Stage 4
    logic v4_reg, dneg4_reg, aneg4_reg, azero4_reg;
    logic [CW-1:0] aabs4_reg;
    logic signed [CW:0] nb4_reg;
    logic [DW-1:0] dmag4_reg;
    logic [DW-1:0] dmag_next;
    logic dneg_next;

    assign b2_next = (DW'(pbh_reg) << (2 * H)) + (DW'(pbm_reg) << (H + 1)) + DW'(pbl_reg);
    assign ac_next = (DW'(pah_reg) << (2 * H))
                   + ((DW'(pam1_reg) + DW'(pam2_reg)) << H) + DW'(pal_reg);

    always_comb
    begin
        dneg_next = 1'b0;
        if (!czero3_reg && (aneg3_reg != cneg3_reg))
        begin
            dmag_next = b2_reg + ac4_reg;
        end
        else if (b2_reg >= ac4_reg)
        begin
            dmag_next = b2_reg - ac4_reg;
        end
        else
        begin
            dmag_next = ac4_reg - b2_reg;
            dneg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aabs1_reg  <= aabs_next;
            babs1_reg  <= babs_next;
            cabs1_reg  <= cabs_next;
            aneg1_reg  <= sa[CW-1];
            cneg1_reg  <= sc[CW-1];
            czero1_reg <= (sc == '0);
            azero1_reg <= (sa == '0);
            nb1_reg    <= -{sb[CW-1], sb};

            pbl_reg    <= babs1_reg[H-1:0] * babs1_reg[H-1:0];
            pbm_reg    <= CW'(babs1_reg[H-1:0] * babs1_reg[CW-1:H]);
            pbh_reg    <= babs1_reg[CW-1:H] * babs1_reg[CW-1:H];
            pal_reg    <= aabs1_reg[H-1:0] * cabs1_reg[H-1:0];
            pam1_reg   <= CW'(aabs1_reg[H-1:0] * cabs1_reg[CW-1:H]);
            pam2_reg   <= CW'(aabs1_reg[CW-1:H] * cabs1_reg[H-1:0]);
            pah_reg    <= aabs1_reg[CW-1:H] * cabs1_reg[CW-1:H];
            aabs2_reg  <= aabs1_reg;
            aneg2_reg  <= aneg1_reg;
            cneg2_reg  <= cneg1_reg;
            czero2_reg <= czero1_reg;
            azero2_reg <= azero1_reg;
            nb2_reg    <= nb1_reg;

            b2_reg     <= b2_next;
            ac4_reg    <= ac_next << 2;
            aabs3_reg  <= aabs2_reg;
            aneg3_reg  <= aneg2_reg;
            cneg3_reg  <= cneg2_reg;
            czero3_reg <= czero2_reg;
            azero3_reg <= azero2_reg;
            nb3_reg    <= nb2_reg;

            dmag4_reg  <= dmag_next;
            dneg4_reg  <= dneg_next;
            aabs4_reg  <= aabs3_reg;
            aneg4_reg  <= aneg3_reg;
            azero4_reg <= azero3_reg;
            nb4_reg    <= nb3_reg;
        end
    end

    assign out_vld = v4_reg;
    assign dmag    = dmag4_reg;
    assign dneg    = dneg4_reg;
    assign azero   = azero4_reg;
    assign aneg    = aneg4_reg;
    assign aabs    = aabs4_reg;
    assign nb      = nb4_reg;

endmodule

>>> rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries an opaque tag alongside; no package dependencies.
module qrs_sqrt #(
    parameter int SW = 33,
    parameter int TW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [2*SW-1:0] rad,
    input  logic [TW-1:0]   in_tag,
    output logic            out_vld,
    output logic [SW-1:0]   root,
    output logic [TW-1:0]   out_tag
);

    logic [SW-1:0]   root_reg [SW];
    logic [SW+1:0]   rem_reg  [SW];
    logic [2*SW-1:0] rad_reg  [SW];
    logic [TW-1:0]   tag_reg  [SW];
    logic            vld_reg  [SW];

    for (genvar k = 0; k < SW; k++)
    begin : g_stage
        logic [SW-1:0]   root_i;
        logic [SW+1:0]   rem_i;
        logic [2*SW-1:0] rad_i;
        logic [TW-1:0]   tag_i;
        logic            vld_i;
        logic [SW+1:0]   rem2;
        logic [SW+1:0]   trial;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign root_i = '0;
            assign rem_i  = '0;
            assign rad_i  = rad;
            assign tag_i  = in_tag;
            assign vld_i  = in_vld;
        end
        else
        begin : g_next
            assign root_i = root_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign rad_i  = rad_reg[k-1];
            assign tag_i  = tag_reg[k-1];
            assign vld_i  = vld_reg[k-1];
        end

        assign rem2  = {rem_i[SW-1:0], rad_i[2*SW-1 -: 2]};
        assign trial = {root_i, 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_i[SW-2:0], ge};
                rem_reg[k]  <= ge ? (rem2 - trial) : rem2;
                rad_reg[k]  <= rad_i << 2;
                tag_reg[k]  <= tag_i;
            end
        end
    end

    assign out_vld = vld_reg[SW-1];
    assign root    = root_reg[SW-1];
    assign out_tag = tag_reg[SW-1];

endmodule

>>> rtl/core/qrs_div.sv
// Pipelined fixed-point divider (nmag * 2^F) / den with 32-bit clamp.
// One quotient bit per stage between the input and output registers; uses qrs_pkg for the result width.
module qrs_div #(
    parameter int NW   = 34,
    parameter int DENW = 33,
    parameter int F    = 16,
    parameter int TW   = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [NW-1:0]                     nmag,
    input  logic [DENW-1:0]                   den,
    input  logic                              neg,
    input  logic                              zero,
    input  logic [TW-1:0]                     in_tag,
    output logic                              out_vld,
    output logic [qrs_pkg::VALUE_WIDTH-1:0]   result,
    output logic                              sat,
    output logic [TW-1:0]                     out_tag
);

    localparam int VW = qrs_pkg::VALUE_WIDTH;
    localparam int XW = ((NW + F > DENW + VW) ? NW + F : DENW + VW) + 1;

    logic [XW-1:0]   numx, denx;
    logic [XW-1:0]   rem_reg  [VW+1];
    logic [VW-1:0]   q_reg    [VW+1];
    logic [DENW-1:0] den_reg  [VW+1];
    logic            ovf_reg  [VW+1];
    logic            neg_reg  [VW+1];
    logic            zero_reg [VW+1];
    logic [TW-1:0]   tag_reg  [VW+1];
    logic            vld_reg  [VW+1];

    assign numx = XW'(nmag) << F;
    assign denx = XW'(den) << VW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= numx;
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= (numx >= denx);
            neg_reg[0]  <= neg;
            zero_reg[0] <= zero;
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar j = 0; j < VW; j++)
    begin : g_stage
        localparam int SH = VW - 1 - j;
        logic [XW-1:0] dsh;
        logic          ge;

        assign dsh = XW'(den_reg[j]) << SH;
        assign ge  = (rem_reg[j] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]     <= ge ? (rem_reg[j] - dsh) : rem_reg[j];
                q_reg[j+1]       <= q_reg[j] | (VW'(ge) << SH);
                den_reg[j+1]     <= den_reg[j];
                ovf_reg[j+1]     <= ovf_reg[j];
                neg_reg[j+1]     <= neg_reg[j];
                zero_reg[j+1]    <= zero_reg[j];
                tag_reg[j+1]     <= tag_reg[j];
            end
        end
    end

    logic [VW:0]   lim;
    logic          big;
    logic [VW-1:0] mag;
    logic [VW-1:0] res_next;
    logic          out_vld_reg, sat_reg;
    logic [VW-1:0] res_reg;
    logic [TW-1:0] out_tag_reg;

    assign lim = neg_reg[VW] ? (VW+1)'(1) << (VW - 1) : ((VW+1)'(1) << (VW - 1)) - 1'b1;
    assign big = ovf_reg[VW] || ({1'b0, q_reg[VW]} > lim);
    assign mag = big ? lim[VW-1:0] : q_reg[VW];
    assign res_next = zero_reg[VW] ? '0 : (neg_reg[VW] ? (~mag + 1'b1) : mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[VW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg     <= res_next;
            sat_reg     <= !zero_reg[VW] && big;
            out_tag_reg <= tag_reg[VW];
        end
    end

    assign out_vld = out_vld_reg;
    assign result  = res_reg;
    assign sat     = sat_reg;
    assign out_tag = out_tag_reg;

endmodule
